// ===== rtl/mrcrc_pkg.sv =====
// mrcrc_pkg: shared types, constants and the byte-wide CRC-32 update
// for the masked record CRC block. No dependencies.
package mrcrc_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam int unsigned POS_W        = 5;
	localparam logic [POS_W-1:0] MASK_A_END   = 5'd4;
	localparam logic [POS_W-1:0] MASK_B_START = 5'd16;
	localparam logic [POS_W-1:0] POSITION_MAX = 5'd20;

	// result handed from the CRC core to the output register
	typedef struct packed {
		logic        push;
		logic [31:0] checksum;
	} core_res_t;

	// reflected CRC-32, eight bit steps over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic pos_masked(input logic [POS_W-1:0] pos);
		return (pos < MASK_A_END) || ((pos >= MASK_B_START) && (pos < POSITION_MAX));
	endfunction

endpackage

// ===== rtl/mrcrc_core.sv =====
// mrcrc_core: running CRC and byte position state, one byte update per cycle while fire is high.
// Depends on mrcrc_pkg.
module mrcrc_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [7:0]              data_s1,
	input  logic                    last_s1,
	output mrcrc_pkg::core_res_t    res
);

	logic [31:0]                    crc_q;
	logic [mrcrc_pkg::POS_W-1:0]    pos_q;
	logic [7:0]                     value;
	logic [31:0]                    crc_next;

	// masked positions enter as zero
	assign value    = mrcrc_pkg::pos_masked(pos_q) ? 8'd0 : data_s1;
	assign crc_next = mrcrc_pkg::crc_byte(crc_q, value);

	assign res.push     = fire && last_s1;
	assign res.checksum = crc_next ^ mrcrc_pkg::CRC_ALL_ONES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrcrc_pkg::CRC_ALL_ONES;
			pos_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				crc_q <= mrcrc_pkg::CRC_ALL_ONES;
				pos_q <= '0;
			end else begin
				crc_q <= crc_next;
				if (pos_q < mrcrc_pkg::POSITION_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mrcrc_pkg::POSITION_MAX)
		else $error("byte position beyond saturation");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (pos_q == '0) && (crc_q == mrcrc_pkg::CRC_ALL_ONES))
		else $error("state not rearmed after last byte");
`endif

endmodule

// ===== rtl/mrcrc_out_reg.sv =====
// mrcrc_out_reg: output register holding a finished checksum until taken.
// Depends on mrcrc_pkg.
module mrcrc_out_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrcrc_pkg::core_res_t    res,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             checksum
);

	logic        valid_q;
	logic [31:0] checksum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			checksum_q <= res.checksum;
		end
	end

	assign out_valid = valid_q;
	assign checksum  = checksum_q;

endmodule

// ===== rtl/masked_record_crc32.sv =====
// masked_record_crc32: top level; input register, CRC core, output register.
// Depends on mrcrc_pkg, mrcrc_core and mrcrc_out_reg.
//
// Reflected CRC-32 (poly 0xEDB88320, init and final XOR all ones) over a
// record streamed one byte per transaction, bytes at positions 0-3 and 16-19
// taken as zero; the position counter saturates at 20 so later bytes are
// never masked. The transaction flagged last_byte yields one checksum
// transaction; other bytes yield none. Throughput is one byte per clock
// while no stall holds the input: the whole 8-bit update is combinational
// logic ahead of the running-CRC register. After its last byte is accepted,
// the checksum passes the input register, then the output register, before
// it is valid. A waiting checksum stalls input only when the next last
// byte reaches the input register; ordinary bytes flow on.
module masked_record_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] checksum
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;
	logic                 advance;
	mrcrc_pkg::core_res_t res;

	// a byte leaves the input register unless it is a last byte and the
	// output register is still full and not being drained
	assign advance  = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mrcrc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.res     (res)
	);

	mrcrc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

`ifndef SYNTHESIS
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !res.push)
		else $error("checksum pushed over a waiting result");

	a_push_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |=> out_valid)
		else $error("pushed checksum not presented");
`endif

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for masked_record_crc32, the masked record CRC-32 block.
// Depends on rtl/mrcrc_pkg.sv (constants) and rtl/masked_record_crc32.sv.
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RAND_ITEMS   = 1450;
	localparam int QUIET_FROM   = 1300;    // no idling on either side past this count
	localparam int HOLD_AT      = 400;     // long receiver hold-off starts here
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;       // margin after the last checksum, to catch strays
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int N_DIRECTED   = 23;

	// one directed byte transaction; exp_sum only counts when has_exp is set
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        has_exp;
		logic [31:0] exp_sum;
	} byte_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] checksum;

	// predictor state: running CRC and position within the current record
	logic [31:0]                 rec_crc;
	logic [mrcrc_pkg::POS_W-1:0] rec_pos;

	logic [31:0] sums_due [$];     // finished checksums still awaited, oldest first
	int          n_errs;
	int          n_sent;
	int          n_cycles;
	logic        quiet;            // end of run: no idling
	logic        hold_off;         // long receiver stall
	byte_row_t   dir_tab [0:N_DIRECTED-1];

	masked_record_crc32 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// reflected CRC-32 over one byte, bit at a time
	function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ mrcrc_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Advance the record model by one byte. Positions 0-3 and 16-19 go in as zero;
	// the position sticks at 20, so long records are unmasked from there on.
	// On the last byte the finished sum is queued (typed value if the row has one).
	task automatic track_byte(input logic [7:0] d, input logic l,
			input logic has_exp, input logic [31:0] exp_sum);
		logic        masked;
		logic [31:0] crc_next;
		masked   = (rec_pos < mrcrc_pkg::MASK_A_END) ||
			((rec_pos >= mrcrc_pkg::MASK_B_START) && (rec_pos < mrcrc_pkg::POSITION_MAX));
		crc_next = crc32_fold(rec_crc, masked ? 8'h00 : d);
		if (rec_pos < mrcrc_pkg::POSITION_MAX)
			rec_pos = rec_pos + 1'b1;
		if (l) begin
			sums_due.push_back(has_exp ? exp_sum : (crc_next ^ mrcrc_pkg::CRC_ALL_ONES));
			rec_crc = mrcrc_pkg::CRC_ALL_ONES;
			rec_pos = '0;
		end else begin
			rec_crc = crc_next;
		end
	endtask

	// Offer one byte transaction and hold it until accepted. Called at a rising
	// edge; returns at the edge of acceptance, so the next call can change the
	// payload in the same step without dropping valid.
	task automatic push_byte(input logic [7:0] d, input logic l,
			input logic has_exp, input logic [31:0] exp_sum);
		in_valid  <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_byte(d, l, has_exp, exp_sum);
		n_sent++;
	endtask

	// Sender-side idle burst of random length with in_valid low
	task automatic sender_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 5)) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		int          len;
		int          shape;
		logic        gappy;
		logic [7:0]  d;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		quiet     = 1'b0;
		hold_off  = 1'b0;
		rec_crc   = mrcrc_pkg::CRC_ALL_ONES;
		rec_pos   = '0;
		n_sent    = 0;

		// Directed part. Record one: a single byte, masked, so it is the CRC of
		// one zero byte. Record two: 22 bytes across both masked windows, the
		// 3/4, 15/16 and 19/20 boundaries, and on into saturation.
		dir_tab = '{
			'{8'hFF, 1'b1, 1'b1, 32'hD202_EF8D},
			'{8'hFF, 1'b0, 1'b0, 32'h0},   // pos 0-3 masked
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b0, 32'h0},   // pos 4, first live byte
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'h01, 1'b0, 1'b0, 32'h0},
			'{8'h80, 1'b0, 1'b0, 32'h0},
			'{8'h12, 1'b0, 1'b0, 32'h0},
			'{8'h34, 1'b0, 1'b0, 32'h0},
			'{8'h56, 1'b0, 1'b0, 32'h0},
			'{8'h78, 1'b0, 1'b0, 32'h0},
			'{8'h9A, 1'b0, 1'b0, 32'h0},
			'{8'hBC, 1'b0, 1'b0, 32'h0},
			'{8'hDE, 1'b0, 1'b0, 32'h0},
			'{8'hF0, 1'b0, 1'b0, 32'h0},   // pos 15, last live byte before window
			'{8'hFF, 1'b0, 1'b0, 32'h0},   // pos 16-19 masked
			'{8'hA5, 1'b0, 1'b0, 32'h0},
			'{8'h5A, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'h7E, 1'b0, 1'b0, 32'h0},   // pos 20, saturates here
			'{8'hFF, 1'b1, 1'b0, 32'h0}    // still 20, unmasked, last
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].has_exp, dir_tab[i].exp_sum);
			if ($urandom_range(0, 2) == 0)
				sender_gap();
		end

		// Random records. Lengths cluster on short records, on the mask B
		// window edges and on saturated long records; gaps come per record so
		// some records stream back to back.
		while (n_sent < N_DIRECTED + RAND_ITEMS) begin
			shape = $urandom_range(0, 9);
			if (shape < 4)
				len = $urandom_range(1, 8);
			else if (shape < 7)
				len = $urandom_range(14, 24);
			else
				len = $urandom_range(20, 48);
			gappy = 1'($urandom_range(0, 1));
			for (int j = 0; j < len; j++) begin
				if (n_sent >= QUIET_FROM)
					quiet <= 1'b1;
				d = 8'($urandom_range(0, 255));
				push_byte(d, (j == len - 1), 1'b0, 32'h0);
				if (gappy && !quiet && $urandom_range(0, 3) == 0)
					sender_gap();
			end
		end
		in_valid <= 1'b0;

		// drain: every checksum back, then a margin to catch strays
		while (sums_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errs == 0 && sums_due.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off
	// ---------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(0, 4);   // start a random stall burst
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long hold-off, counted here; the sender keeps offering bytes meanwhile,
	// so a waiting checksum backs up into the input
	initial begin
		@(posedge clk);
		while (n_sent < HOLD_AT) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// Checksum transactions against the oldest expectation
	// ---------------------------------------------------------------------
	initial n_errs = 0;

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (sums_due.size() == 0) begin
				if (n_errs < MAX_REPORTS)
					$display("unexpected checksum transaction: got %h", checksum);
				n_errs++;
			end else begin
				want = sums_due.pop_front();
				if (checksum !== want) begin
					if (n_errs < MAX_REPORTS)
						$display("checksum mismatch: expected %h got %h", want, checksum);
					n_errs++;
				end
			end
		end
	end

	// watchdog
	initial n_cycles = 0;

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule
